FILE: sv/scl_pkg.sv
package scl_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [SIZE_W-1:0] MAX_WIDTH_V  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_V = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(48);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] e;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] f;
    logic [PIX_W-1:0] h;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } block_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] rd_addr_next;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_center;
    logic [PIX_W-1:0] wr_above;
  } mem_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] center_next;
    logic [PIX_W-1:0] above;
  } mem_rsp_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

FILE: sv/scl_line_store.sv
module scl_line_store
  import scl_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [PIX_W-1:0] center_mem [MAX_WIDTH];
  logic [PIX_W-1:0] above_mem  [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      center_mem[req.wr_addr] <= req.wr_center;
      above_mem[req.wr_addr]  <= req.wr_above;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rsp.center      <= center_mem[req.rd_addr];
      rsp.center_next <= center_mem[req.rd_addr_next];
      rsp.above       <= above_mem[req.rd_addr];
    end
  end

endmodule

FILE: sv/scl_block_out.sv
module scl_block_out
  import scl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             emit,
  input  block_t           blk,
  output logic             hold,
  output logic             block_valid,
  input  logic             block_stall,
  output logic [PIX_W-1:0] out_top_left,
  output logic [PIX_W-1:0] out_top_right,
  output logic [PIX_W-1:0] out_bottom_left,
  output logic [PIX_W-1:0] out_bottom_right,
  output logic [ROW_W-1:0] source_row,
  output logic [COL_W-1:0] source_column,
  output logic             frame_last
);

  logic [PIX_W-1:0] p0, p1, p2, p3;

  assign hold = block_valid && block_stall;

  always_comb begin
    p0 = blk.e;
    p1 = blk.e;
    p2 = blk.e;
    p3 = blk.e;
    if (blk.b != blk.h && blk.d != blk.f) begin
      if (blk.d == blk.b) p0 = blk.d;
      if (blk.b == blk.f) p1 = blk.f;
      if (blk.d == blk.h) p2 = blk.d;
      if (blk.h == blk.f) p3 = blk.f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= 1'b0;
    end else if (!hold) begin
      block_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && emit) begin
      out_top_left     <= p0;
      out_top_right    <= p1;
      out_bottom_left  <= p2;
      out_bottom_right <= p3;
      source_row       <= blk.row;
      source_column    <= blk.col;
      frame_last       <= blk.last;
    end
  end

endmodule

FILE: sv/scale2x_pixel_upscaler.sv
// Scale2x pixel-art upscaler.
// Item channel (item_valid / item_stall, fields mode and pixel) takes 8-bit
// palette indices in raster order, mode 0, one per cycle. The block for a
// source pixel leaves on the block channel (block_valid / block_stall) when
// the pixel below it arrives; after the last pixel of a frame, one mode 1
// item per block of the final row flushes that row, frame_last marking the
// final block. Items that do not fit the phase (pixel during flush, flush
// outside flush) are taken and dropped.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 width, 1 height)
// and cfg_data; cfg_ready is always high. Write only while idle.
// Throughput is one item per cycle while the output is not stalled, set by
// the single read-modify-write pass through the line-store memories. A block
// reaches the outputs through the memory read, registered at the accepting
// edge, and then the output register. A stalled output register holds its
// block; one more item is taken into the read stage, then item_stall rises
// until the output drains.
// Reset clears counters, flush state and valid flags and sets both sizes to
// 48; line-store contents are not cleared and need no clearing pass.
module scale2x_pixel_upscaler
  import scl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 mode,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 block_valid,
  input  logic                 block_stall,
  output logic [PIX_W-1:0]     out_top_left,
  output logic [PIX_W-1:0]     out_top_right,
  output logic [PIX_W-1:0]     out_bottom_left,
  output logic [PIX_W-1:0]     out_bottom_right,
  output logic [ROW_W-1:0]     source_row,
  output logic [COL_W-1:0]     source_column,
  output logic                 frame_last
);

  logic [SIZE_W-1:0] image_width, image_height;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              flush_pending;

  logic              accept, pix_act, fl_act, last_col, last_row;
  logic [SIZE_W-1:0] col_plus, row_plus;

  logic              s1_valid, s1_flush, s1_emit, s1_last;
  logic              s1_b_sel, s1_d_sel, s1_f_sel;
  logic              s1_fwd_e, s1_fwd_f;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic [PIX_W-1:0]  s1_px, fwd_center, fwd_above;
  logic [PIX_W-1:0]  last_e;

  logic [PIX_W-1:0]  e_cur, f_raw, b_raw;
  logic              out_hold, s1_leave, wr_en;
  block_t            blk;
  mem_req_t          mreq;
  mem_rsp_t          mrsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(image_width, MAX_WIDTH_V);
  assign h_eff = eff_size(image_height, MAX_HEIGHT_V);

  assign item_stall = s1_valid && out_hold;
  assign accept     = item_valid && !item_stall;
  assign pix_act    = (mode == MODE_PIXEL) && !flush_pending;
  assign fl_act     = (mode == MODE_FLUSH) && flush_pending;
  assign col_plus   = {1'b0, column_count} + SIZE_W'(1);
  assign row_plus   = {1'b0, row_count} + SIZE_W'(1);
  assign last_col   = col_plus >= w_eff;
  assign last_row   = row_plus >= h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      flush_pending <= 1'b0;
    end else if (accept && pix_act) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) flush_pending <= 1'b1;
        else row_count <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end else if (accept && fl_act) begin
      if (last_col) begin
        column_count  <= '0;
        row_count     <= '0;
        flush_pending <= 1'b0;
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  assign s1_leave = s1_valid && !out_hold;
  assign wr_en    = s1_leave && !s1_flush;

  always_comb begin
    mreq.rd_en        = accept;
    mreq.rd_addr      = column_count;
    mreq.rd_addr_next = column_count + COL_W'(1);
    mreq.wr_en        = wr_en;
    mreq.wr_addr      = s1_col;
    mreq.wr_center    = s1_px;
    mreq.wr_above     = e_cur;
  end

  scl_line_store u_store (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= accept && (pix_act || fl_act);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush   <= fl_act;
      s1_emit    <= fl_act || (row_count != '0);
      s1_last    <= fl_act && last_col;
      s1_col     <= column_count;
      s1_row     <= fl_act ? row_count : row_count - ROW_W'(1);
      s1_px      <= pixel;
      s1_b_sel   <= fl_act ? (row_count != '0) : (row_count > ROW_W'(1));
      s1_d_sel   <= column_count != '0;
      s1_f_sel   <= !last_col;
      s1_fwd_e   <= wr_en && (column_count == s1_col);
      s1_fwd_f   <= wr_en && (mreq.rd_addr_next == s1_col);
      fwd_center <= s1_px;
      fwd_above  <= e_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      last_e <= e_cur;
    end
  end

  assign e_cur = s1_fwd_e ? fwd_center : mrsp.center;
  assign f_raw = s1_fwd_f ? fwd_center : mrsp.center_next;
  assign b_raw = s1_fwd_e ? fwd_above : mrsp.above;

  always_comb begin
    blk.e    = e_cur;
    blk.b    = s1_b_sel ? b_raw : e_cur;
    blk.d    = s1_d_sel ? last_e : e_cur;
    blk.f    = s1_f_sel ? f_raw : e_cur;
    blk.h    = s1_flush ? e_cur : s1_px;
    blk.row  = s1_row;
    blk.col  = s1_col;
    blk.last = s1_last;
  end

  scl_block_out u_out (
    .clk              (clk),
    .rst              (rst),
    .emit             (s1_valid && s1_emit),
    .blk              (blk),
    .hold             (out_hold),
    .block_valid      (block_valid),
    .block_stall      (block_stall),
    .out_top_left     (out_top_left),
    .out_top_right    (out_top_right),
    .out_bottom_left  (out_bottom_left),
    .out_bottom_right (out_bottom_right),
    .source_row       (source_row),
    .source_column    (source_column),
    .frame_last       (frame_last)
  );

endmodule
